// ===== rtl/core/xcfd_pkg.sv =====
// Shared types and codes for the XOR-checked frame deframer.
`default_nettype none

package xcfd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CodeW  = 2;
  localparam int unsigned CfgIdxW = 2;

  // parser phases
  localparam logic [PhaseW-1:0] PH_HUNT    = 3'd0;
  localparam logic [PhaseW-1:0] PH_LEN     = 3'd1;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 3'd2;
  localparam logic [PhaseW-1:0] PH_CHECK   = 3'd3;
  localparam logic [PhaseW-1:0] PH_TAIL    = 3'd4;

  typedef enum logic [CodeW-1:0] {
    ST_GOOD     = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_TAIL     = 2'd2,
    ST_LENGTH   = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEAD  = 2'd0,
    CFG_TAIL  = 2'd1,
    CFG_MAXPL = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] head_byte;
    logic [ByteW-1:0] tail_byte;
    logic [ByteW-1:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             is_status;
    logic [CodeW-1:0] status_code;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/xcfd_if.sv =====
// Valid/ready channel interfaces for received bytes and parser results.
`default_nettype none

interface xcfd_byte_if;
  logic                      valid;
  logic                      ready;
  logic [xcfd_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xcfd_res_if;
  logic                       valid;
  logic                       ready;
  logic [xcfd_pkg::ByteW-1:0] out_byte;
  logic                       is_status;
  logic [xcfd_pkg::CodeW-1:0] status_code;

  modport source (output valid, output out_byte, output is_status, output status_code,
                  input ready);
  modport sink   (input valid, input out_byte, input is_status, input status_code,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/xcfd_parser.sv =====
// Frame parser: phase, length count, running XOR and one-byte step logic.
`default_nettype none

module xcfd_parser (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic [xcfd_pkg::ByteW-1:0] byte_i,
  input  wire xcfd_pkg::cfg_t             cfg_i,
  output logic                            res_vld_o,
  output xcfd_pkg::res_t                  res_o
);

  logic [xcfd_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [xcfd_pkg::ByteW-1:0]  left_q, left_d;
  logic [xcfd_pkg::ByteW-1:0]  xor_q, xor_d;
  logic                        ok_q, ok_d;

  always_comb begin
    phase_d   = phase_q;
    left_d    = left_q;
    xor_d     = xor_q;
    ok_d      = ok_q;
    res_vld_o = 1'b0;
    res_o     = '0;
    case (phase_q)
      xcfd_pkg::PH_LEN: begin
        if (byte_i > cfg_i.max_payload) begin
          phase_d           = xcfd_pkg::PH_HUNT;
          left_d            = '0;
          res_vld_o         = 1'b1;
          res_o.is_status   = 1'b1;
          res_o.status_code = xcfd_pkg::ST_LENGTH;
        end else begin
          xor_d   = '0;
          ok_d    = 1'b0;
          left_d  = byte_i;
          phase_d = (byte_i == '0) ? xcfd_pkg::PH_CHECK : xcfd_pkg::PH_PAYLOAD;
        end
      end
      xcfd_pkg::PH_PAYLOAD: begin
        xor_d  = xor_q ^ byte_i;
        left_d = left_q - xcfd_pkg::ByteW'(1);
        // a count of zero wraps and keeps the frame in payload, as the count does
        if (left_q == xcfd_pkg::ByteW'(1)) begin
          phase_d = xcfd_pkg::PH_CHECK;
        end
        res_vld_o      = 1'b1;
        res_o.out_byte = byte_i;
      end
      xcfd_pkg::PH_CHECK: begin
        ok_d    = (byte_i == xor_q);
        phase_d = xcfd_pkg::PH_TAIL;
      end
      xcfd_pkg::PH_TAIL: begin
        phase_d         = xcfd_pkg::PH_HUNT;
        res_vld_o       = 1'b1;
        res_o.is_status = 1'b1;
        if (byte_i != cfg_i.tail_byte) begin
          res_o.status_code = xcfd_pkg::ST_TAIL;
        end else if (ok_q) begin
          res_o.status_code = xcfd_pkg::ST_GOOD;
        end else begin
          res_o.status_code = xcfd_pkg::ST_CHECKSUM;
        end
      end
      default: begin
        phase_d = (byte_i == cfg_i.head_byte) ? xcfd_pkg::PH_LEN : xcfd_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= xcfd_pkg::PH_HUNT;
      left_q  <= '0;
      xor_q   <= '0;
      ok_q    <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      xor_q   <= xor_d;
      ok_q    <= ok_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/xcfd_out_stage.sv =====
// Result register between the parser and the output channel.
`default_nettype none

module xcfd_out_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire xcfd_pkg::res_t res_i,
  output logic                free_o,
  xcfd_res_if.source          res_o
);

  logic           vld_q, vld_d;
  xcfd_pkg::res_t data_q;

  // free when empty or the held transaction leaves this cycle
  assign free_o = !vld_q || res_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (res_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid       = vld_q;
  assign res_o.out_byte    = data_q.out_byte;
  assign res_o.is_status   = data_q.is_status;
  assign res_o.status_code = data_q.status_code;

endmodule

`default_nettype wire

// ===== rtl/core/xor_checked_frame_deframer.sv =====
// An accepted byte passes the input register and then the result register on its way to the output channel.
// Throughput: one byte per cycle unless the output stalls, also for a byte that yields no result.
// The input register advances only when the result register is free, so a stalled
// output holds one byte at each stage and no more.
// Reset (rst_ni low, asynchronous): both stages empty, parser hunting for the head
// byte, registers back to head 0xAA, tail 0x55, max payload 255.
`default_nettype none

module xor_checked_frame_deframer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [xcfd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [xcfd_pkg::ByteW-1:0]   cfg_wdata_i,
  xcfd_byte_if.sink                         rx_i,
  xcfd_res_if.source                        res_o
);

  xcfd_pkg::cfg_t             cfg_q;
  logic                       in_vld_q, in_vld_d;
  logic [xcfd_pkg::ByteW-1:0] in_byte_q;
  logic                       out_free;
  logic                       step;
  logic                       res_vld;
  xcfd_pkg::res_t             res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_byte   <= 8'hAA;
      cfg_q.tail_byte   <= 8'h55;
      cfg_q.max_payload <= 8'hFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        xcfd_pkg::CFG_HEAD:  cfg_q.head_byte   <= cfg_wdata_i;
        xcfd_pkg::CFG_TAIL:  cfg_q.tail_byte   <= cfg_wdata_i;
        xcfd_pkg::CFG_MAXPL: cfg_q.max_payload <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register moves on to the parser whenever the result side can take it
  assign step       = in_vld_q && out_free;
  assign rx_i.ready = !in_vld_q || out_free;

  always_comb begin
    in_vld_d = in_vld_q;
    if (rx_i.valid && rx_i.ready) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  xcfd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte_q),
    .cfg_i     (cfg_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  xcfd_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step && res_vld),
    .res_i  (res),
    .free_o (out_free),
    .res_o  (res_o)
  );

  a_status_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.is_status |-> res_o.out_byte == '0)
    else $error("status transaction carries a payload byte");

  a_payload_good_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.is_status |-> res_o.status_code == xcfd_pkg::ST_GOOD)
    else $error("payload transaction carries a status code");

  a_input_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && res_o.valid && !res_o.ready |=> in_vld_q && $stable(in_byte_q))
    else $error("input stage lost a byte while the output was stalled");

  a_out_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> res_o.valid && $stable(res_o.out_byte)
      && $stable(res_o.is_status) && $stable(res_o.status_code))
    else $error("result register dropped a transaction under backpressure");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the XOR-checked frame deframer.
`timescale 1ns / 1ps

module tb;
  import xcfd_pkg::*;

  typedef enum logic [1:0] {
    K_PRED,   // expectation from the parser model
    K_QUIET,  // typed: no result
    K_RESULT, // typed: the result in the row
    K_CFG     // register write, not a byte
  } step_kind_e;

  typedef struct packed {
    step_kind_e       kind;
    cfg_idx_e         idx;
    logic [ByteW-1:0] data;
    res_t             want;
  } step_t;

  localparam res_t NO_RES = '0;

  // Starts on the reset register values: head 0xAA, tail 0x55, max payload 255 (later set to 3).
  localparam step_t DIR_STEPS [25] = '{
    '{K_QUIET,  CFG_HEAD,  8'h00, NO_RES},                      // dropped while hunting
    '{K_QUIET,  CFG_HEAD,  8'hAA, NO_RES},
    '{K_QUIET,  CFG_HEAD,  8'h00, NO_RES},                      // empty payload
    '{K_QUIET,  CFG_HEAD,  8'h00, NO_RES},
    '{K_RESULT, CFG_HEAD,  8'h55, '{8'h00, 1'b1, ST_GOOD}},
    '{K_QUIET,  CFG_HEAD,  8'hAA, NO_RES},
    '{K_QUIET,  CFG_HEAD,  8'h02, NO_RES},
    '{K_PRED,   CFG_HEAD,  8'hAA, NO_RES},                      // head value as payload
    '{K_RESULT, CFG_HEAD,  8'hFF, '{8'hFF, 1'b0, ST_GOOD}},
    '{K_QUIET,  CFG_HEAD,  8'h54, NO_RES},
    '{K_RESULT, CFG_HEAD,  8'h55, '{8'h00, 1'b1, ST_CHECKSUM}},
    '{K_QUIET,  CFG_HEAD,  8'hAA, NO_RES},
    '{K_QUIET,  CFG_HEAD,  8'h01, NO_RES},
    '{K_RESULT, CFG_HEAD,  8'h00, '{8'h00, 1'b0, ST_GOOD}},
    '{K_QUIET,  CFG_HEAD,  8'h00, NO_RES},
    '{K_RESULT, CFG_HEAD,  8'h00, '{8'h00, 1'b1, ST_TAIL}},
    '{K_QUIET,  CFG_HEAD,  8'hAA, NO_RES},
    '{K_QUIET,  CFG_HEAD,  8'h00, NO_RES},
    '{K_QUIET,  CFG_HEAD,  8'h01, NO_RES},                      // bad checksum and tail
    '{K_RESULT, CFG_HEAD,  8'hFF, '{8'h00, 1'b1, ST_TAIL}},
    '{K_CFG,    CFG_MAXPL, 8'h03, NO_RES},
    '{K_QUIET,  CFG_HEAD,  8'hAA, NO_RES},
    '{K_RESULT, CFG_HEAD,  8'h04, '{8'h00, 1'b1, ST_LENGTH}},
    '{K_QUIET,  CFG_HEAD,  8'hAA, NO_RES},                      // hunt resumes at once
    '{K_RESULT, CFG_HEAD,  8'hFF, '{8'h00, 1'b1, ST_LENGTH}}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  cfg_idx_e         cfg_idx;
  logic [ByteW-1:0] cfg_wdata;

  xcfd_byte_if rx_if ();
  xcfd_res_if  res_if ();

  xor_checked_frame_deframer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // parser model state and register shadow
  logic [PhaseW-1:0] prs_phase;
  logic [ByteW-1:0]  prs_left;
  logic [ByteW-1:0]  prs_xor;
  logic              prs_sum_ok;
  cfg_t              cfg_shadow;

  res_t pending_results[$];
  res_t seen_want;
  int   mismatches = 0;
  bit   rx_burst = 1'b0;
  bit   res_burst = 1'b0;
  int   res_hold_cycles = 0;
  int   phase_bytes = 0;

  // Advances the parser model by one byte; returns 1 when the byte yields a result.
  function automatic bit deframe_byte(input logic [ByteW-1:0] b, output res_t r);
    r = NO_RES;
    case (prs_phase)
      PH_LEN: begin
        if (b > cfg_shadow.max_payload) begin
          prs_phase = PH_HUNT;
          prs_left = '0;
          r.is_status = 1'b1;
          r.status_code = ST_LENGTH;
          return 1'b1;
        end
        prs_xor = '0;
        prs_sum_ok = 1'b0;
        prs_left = b;
        prs_phase = (b == '0) ? PH_CHECK : PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        prs_xor = prs_xor ^ b;
        prs_left = prs_left - 1'b1;
        if (prs_left == '0) prs_phase = PH_CHECK;
        r.out_byte = b;
        return 1'b1;
      end
      PH_CHECK: begin
        prs_sum_ok = (b == prs_xor);
        prs_phase = PH_TAIL;
        return 1'b0;
      end
      PH_TAIL: begin
        prs_phase = PH_HUNT;
        r.is_status = 1'b1;
        if (b != cfg_shadow.tail_byte) r.status_code = ST_TAIL;
        else r.status_code = prs_sum_ok ? ST_GOOD : ST_CHECKSUM;
        return 1'b1;
      end
      default: begin
        prs_phase = (b == cfg_shadow.head_byte) ? PH_LEN : PH_HUNT;
        return 1'b0;
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_byte(input logic [ByteW-1:0] b, input step_kind_e kind = K_PRED,
                           input res_t want = NO_RES);
    int   gap;
    res_t r;
    bit   has;
    gap = rx_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      rx_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_if.valid = 1'b1;
    rx_if.rx_byte = b;
    do @(posedge clk_i); while (!rx_if.ready);
    has = deframe_byte(b, r);
    if (kind == K_PRED && has) pending_results.push_back(r);
    else if (kind == K_RESULT) pending_results.push_back(want);
    phase_bytes++;
    @(negedge clk_i);
  endtask

  // Bytes that yield nothing may still be in flight once the queue empties.
  task automatic drain_results();
    rx_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [ByteW-1:0] v);
    drain_results();
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      CFG_HEAD: cfg_shadow.head_byte = v;
      CFG_TAIL: cfg_shadow.tail_byte = v;
      default:  cfg_shadow.max_payload = v;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got byte %02h status %0b code %0d",
                 $time, res_if.out_byte, res_if.is_status, res_if.status_code);
        mismatches++;
      end else begin
        seen_want = pending_results.pop_front();
        if (res_if.out_byte !== seen_want.out_byte || res_if.is_status !== seen_want.is_status
            || res_if.status_code !== seen_want.status_code) begin
          $display({"%0t: mismatch, expected byte %02h status %0b code %0d,",
                    " got byte %02h status %0b code %0d"},
                   $time, seen_want.out_byte, seen_want.is_status, seen_want.status_code,
                   res_if.out_byte, res_if.is_status, res_if.status_code);
          mismatches++;
        end
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : res_side
    int stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (res_hold_cycles > 0) begin
        res_if.ready = 1'b0;
        repeat (res_hold_cycles) @(negedge clk_i);
        res_hold_cycles = 0;
      end
      stall = res_burst ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        res_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready = 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int               frames;
    int               pick;
    int               len;
    int               cap;
    int               maxp;
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] d;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_HEAD;
    cfg_wdata = '0;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    prs_phase = PH_HUNT;
    prs_left = '0;
    prs_xor = '0;
    prs_sum_ok = 1'b0;
    cfg_shadow = '{8'hAA, 8'h55, 8'hFF};
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DIR_STEPS[i]) begin
      if (DIR_STEPS[i].kind == K_CFG) write_reg(DIR_STEPS[i].idx, DIR_STEPS[i].data);
      else send_byte(DIR_STEPS[i].data, DIR_STEPS[i].kind, DIR_STEPS[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_HEAD, 8'h00);
          write_reg(CFG_TAIL, 8'hFF);
          write_reg(CFG_MAXPL, 8'h00);
        end
        1: begin
          write_reg(CFG_HEAD, 8'hFF);
          write_reg(CFG_TAIL, 8'h00);
          write_reg(CFG_MAXPL, 8'hFF);
        end
        default: begin
          write_reg(CFG_HEAD, ByteW'($urandom_range(0, 255)));
          write_reg(CFG_TAIL, ByteW'($urandom_range(0, 255)));
          write_reg(CFG_MAXPL, ($urandom_range(0, 3) == 0) ? ByteW'($urandom_range(0, 255))
                                                           : ByteW'($urandom_range(0, 15)));
        end
      endcase
      rx_burst = (ph == 3);
      res_burst = (ph == 3 || ph == 5);
      maxp = int'(cfg_shadow.max_payload);
      cap = (maxp > 12) ? 12 : maxp;
      phase_bytes = 0;
      frames = 0;
      while (phase_bytes < 180) begin
        frames++;
        if (ph == 4 && frames == 10) res_hold_cycles = 300;
        if (ph == 6 && frames == 10) drain_results();
        pick = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, maxp) : $urandom_range(0, cap);
        if (pick < 75 || (pick < 85 && maxp == 255)) begin
          send_byte(cfg_shadow.head_byte);
          send_byte(ByteW'(len));
          sum = '0;
          for (int k = 0; k < len; k++) begin
            d = ByteW'($urandom_range(0, 255));
            sum ^= d;
            send_byte(d);
          end
          if ($urandom_range(0, 9) == 0) sum = sum ^ ByteW'($urandom_range(1, 255));
          send_byte(sum);
          if ($urandom_range(0, 9) == 0) begin
            send_byte(cfg_shadow.tail_byte ^ ByteW'($urandom_range(1, 255)));
          end else begin
            send_byte(cfg_shadow.tail_byte);
          end
        end else if (pick < 85) begin
          send_byte(cfg_shadow.head_byte);
          send_byte(ByteW'($urandom_range(maxp + 1, 255)));
        end else if (pick < 92) begin
          // frame cut short; the next frame's bytes land inside it
          send_byte(cfg_shadow.head_byte);
          send_byte(ByteW'(len));
          repeat ($urandom_range(0, len)) send_byte(ByteW'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(1, 4)) send_byte(ByteW'($urandom_range(0, 255)));
        end
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/xcfd_pkg.sv
rtl/core/xcfd_if.sv
rtl/core/xcfd_parser.sv
rtl/core/xcfd_out_stage.sv
rtl/core/xor_checked_frame_deframer.sv
tb/tb.sv
